FILE: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used in the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: sv/fcs_pkg.sv
// ---------------------------------------------------------------------------
// fcs_pkg
// Shared types, constants and helpers of the follow camera smoother.
// ---------------------------------------------------------------------------
package fcs_pkg;

  localparam int VAL_W  = 32;
  localparam int Q_W    = 16;
  localparam int T_W    = 36;
  localparam int PROD_W = Q_W + T_W;
  localparam int ACC_W  = 54;
  localparam int SUM_W  = 42;
  localparam int IN_W   = 160;
  localparam int OUT_W  = 192;

  localparam logic signed [31:0] OFFSET_X_RST = 32'sd0;
  localparam logic signed [31:0] OFFSET_Y_RST = 32'sd655360;
  localparam logic signed [31:0] OFFSET_Z_RST = -32'sd655360;
  localparam logic [30:0]        LOOK_RST     = 31'd983040;
  localparam logic signed [15:0] AIM_GAIN     = 16'sd6554;

  localparam logic [1:0] REG_OFFSET_X = 2'd0;
  localparam logic [1:0] REG_OFFSET_Y = 2'd1;
  localparam logic [1:0] REG_OFFSET_Z = 2'd2;
  localparam logic [1:0] REG_LOOK     = 2'd3;

  localparam logic [3:0] OP_NOP    = 4'd0;
  localparam logic [3:0] OP_TMUL0  = 4'd1;
  localparam logic [3:0] OP_TMUL1  = 4'd2;
  localparam logic [3:0] OP_TSTORE = 4'd3;
  localparam logic [3:0] OP_R0     = 4'd4;
  localparam logic [3:0] OP_R1     = 4'd5;
  localparam logic [3:0] OP_R2     = 4'd6;
  localparam logic [3:0] OP_TGT    = 4'd7;
  localparam logic [3:0] OP_UPD    = 4'd8;
  localparam logic [3:0] OP_FIN    = 4'd9;

  typedef struct packed {
    logic       load;
    logic       out_load;
    logic [3:0] op;
    logic       vec;
    logic [1:0] comp;
  } fcs_cmd_t;

  function automatic logic [1:0] idx_a(input logic [1:0] c);
    case (c)
      2'd0:    idx_a = 2'd1;
      2'd1:    idx_a = 2'd2;
      default: idx_a = 2'd0;
    endcase
  endfunction

  function automatic logic [1:0] idx_b(input logic [1:0] c);
    case (c)
      2'd0:    idx_b = 2'd2;
      2'd1:    idx_b = 2'd0;
      default: idx_b = 2'd1;
    endcase
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] x);
    if (x > 42'sd2147483647) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (x < -42'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = x[31:0];
    end
  endfunction

endpackage

FILE: sv/follow_camera_smoother_top.sv
// ---------------------------------------------------------------------------
// follow_camera_smoother_top
// Follow camera: rotates offset and look vectors, smooths eye and aim.
// ---------------------------------------------------------------------------
// Each accepted item runs through a single 16x36
// multiply-accumulate unit in 54 sequenced steps: for the offset vector and
// then the look vector, three steps per axis build the doubled cross product
// and six steps per axis form the rotated sum, the target, the smoothing and
// the aim gain. The output register is then loaded as the controller returns
// to accept, so no new item is taken before the last one is loaded. The next
// item may be taken while the previous result waits on the output; its result
// then waits until that transfer completes.
module follow_camera_smoother_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [159:0] s_tdata,  // object_x, object_y, object_z, quat_w, quat_x, quat_y, quat_z
  input  logic         s_tuser,  // operation
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [191:0] m_tdata,  // eye_x, eye_y, eye_z, aim_x, aim_y, aim_z
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  fcs_pkg::fcs_cmd_t cmd;

  fcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  fcs_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_tdata),
    .in_smooth (s_tuser),
    .cmd       (cmd),
    .out_data  (m_tdata)
  );

endmodule

FILE: sv/fcs_ctrl.sv
// ---------------------------------------------------------------------------
// fcs_ctrl
// Sequencer: steps the shared multiplier through both rotations and updates.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fcs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  output logic             m_tvalid,
  input  logic             m_tready,
  output fcs_pkg::fcs_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  logic [1:0] state;
  logic       vec;
  logic       grp;
  logic [1:0] comp;
  logic [2:0] ph;
  logic       out_valid;
  logic       last_ph;
  logic       last;
  logic       out_load;
  logic [3:0] op;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;
  assign last_ph  = grp ? (ph == 3'd5) : (ph == 3'd2);
  assign last     = last_ph && (comp == 2'd2) && grp && vec;
  assign out_load = (state == ST_WAIT) && (!out_valid || m_tready);

  always_comb begin
    op = fcs_pkg::OP_NOP;
    if (state == ST_RUN) begin
      if (!grp) begin
        case (ph)
          3'd0:    op = fcs_pkg::OP_TMUL0;
          3'd1:    op = fcs_pkg::OP_TMUL1;
          default: op = fcs_pkg::OP_TSTORE;
        endcase
      end else begin
        case (ph)
          3'd0:    op = fcs_pkg::OP_R0;
          3'd1:    op = fcs_pkg::OP_R1;
          3'd2:    op = fcs_pkg::OP_R2;
          3'd3:    op = fcs_pkg::OP_TGT;
          3'd4:    op = fcs_pkg::OP_UPD;
          default: op = fcs_pkg::OP_FIN;
        endcase
      end
    end
  end

  assign cmd.load     = s_tvalid && s_tready;
  assign cmd.out_load = out_load;
  assign cmd.op       = op;
  assign cmd.vec      = vec;
  assign cmd.comp     = comp;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      vec       <= 1'b0;
      grp       <= 1'b0;
      comp      <= 2'd0;
      ph        <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_RUN;
            vec   <= 1'b0;
            grp   <= 1'b0;
            comp  <= 2'd0;
            ph    <= 3'd0;
          end
        end
        ST_RUN: begin
          if (last) begin
            state <= ST_WAIT;
          end else if (!last_ph) begin
            ph <= ph + 3'd1;
          end else begin
            ph <= 3'd0;
            if (comp != 2'd2) begin
              comp <= comp + 2'd1;
            end else begin
              comp <= 2'd0;
              grp  <= ~grp;
              if (grp) begin
                vec <= 1'b1;
              end
            end
          end
        end
        ST_WAIT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_NEXT(a_start, clk, rst, s_tvalid && s_tready, (state == ST_RUN) && (ph == 3'd0) && !vec)
  `ASSERT_IMPLIES(a_comp_range, clk, rst, state == ST_RUN, (comp != 2'd3) && (ph != 3'd7))
  `ASSERT_NEXT(a_run_end, clk, rst, (state == ST_RUN) && last, (state == ST_WAIT))

endmodule

FILE: sv/fcs_datapath.sv
// ---------------------------------------------------------------------------
// fcs_datapath
// Config registers, shared multiply-accumulate, rotation and smoothing state.
// ---------------------------------------------------------------------------
module fcs_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [31:0]                  cfg_data,
  input  logic [fcs_pkg::IN_W-1:0]     in_data,
  input  logic                         in_smooth,
  input  fcs_pkg::fcs_cmd_t            cmd,
  output logic [fcs_pkg::OUT_W-1:0]    out_data
);

  logic signed [31:0]                 offset [3];
  logic [30:0]                        look;
  logic                               smooth;
  logic signed [31:0]                 pos [3];
  logic signed [15:0]                 q [4];
  logic signed [fcs_pkg::T_W-1:0]     t [3];
  logic signed [fcs_pkg::ACC_W-1:0]   acc;
  logic signed [fcs_pkg::ACC_W-1:0]   acc_next;
  logic signed [31:0]                 tgt;
  logic signed [31:0]                 eye [3];
  logic signed [31:0]                 aim [3];

  logic [1:0]                         ia;
  logic [1:0]                         ib;
  logic signed [15:0]                 qa;
  logic signed [15:0]                 qb;
  logic signed [31:0]                 va;
  logic signed [31:0]                 vb;
  logic signed [31:0]                 vc;
  logic signed [15:0]                 ma;
  logic signed [fcs_pkg::T_W-1:0]     mb;
  logic signed [fcs_pkg::PROD_W-1:0]  prod;
  logic signed [fcs_pkg::ACC_W-1:0]   prod_x;
  logic signed [33:0]                 eye_d;
  logic signed [33:0]                 eye_r;
  logic signed [31:0]                 eye_new;
  logic signed [31:0]                 aim_new;
  logic signed [31:0]                 tgt_new;

  function automatic logic signed [31:0] vsel(input logic v, input logic [1:0] k,
                                              input logic signed [31:0] ofs,
                                              input logic [30:0] lk);
    if (!v) begin
      vsel = ofs;
    end else if (k == 2'd2) begin
      vsel = {1'b0, lk};
    end else begin
      vsel = 32'sd0;
    end
  endfunction

  assign ia = fcs_pkg::idx_a(cmd.comp);
  assign ib = fcs_pkg::idx_b(cmd.comp);
  assign qa = q[ia + 2'd1];
  assign qb = q[ib + 2'd1];
  assign va = vsel(cmd.vec, ia, offset[ia], look);
  assign vb = vsel(cmd.vec, ib, offset[ib], look);
  assign vc = vsel(cmd.vec, cmd.comp, offset[cmd.comp], look);

  always_comb begin
    ma = 16'sd0;
    mb = '0;
    case (cmd.op)
      fcs_pkg::OP_TMUL0: begin
        ma = qa;
        mb = fcs_pkg::T_W'(vb);
      end
      fcs_pkg::OP_TMUL1: begin
        ma = qb;
        mb = fcs_pkg::T_W'(va);
      end
      fcs_pkg::OP_R0: begin
        ma = q[0];
        mb = t[cmd.comp];
      end
      fcs_pkg::OP_R1: begin
        ma = qa;
        mb = t[ib];
      end
      fcs_pkg::OP_R2: begin
        ma = qb;
        mb = t[ia];
      end
      fcs_pkg::OP_UPD: begin
        ma = fcs_pkg::AIM_GAIN;
        mb = fcs_pkg::T_W'(tgt) - fcs_pkg::T_W'(aim[cmd.comp]);
      end
      default: begin
        ma = 16'sd0;
        mb = '0;
      end
    endcase
  end

  assign prod   = ma * mb;
  assign prod_x = fcs_pkg::ACC_W'(prod);

  always_comb begin
    case (cmd.op)
      fcs_pkg::OP_TMUL0: acc_next = prod_x + (54'sd1 <<< 12);
      fcs_pkg::OP_TMUL1: acc_next = acc - prod_x;
      fcs_pkg::OP_R0:    acc_next = (fcs_pkg::ACC_W'(vc) <<< 14) + (54'sd1 <<< 13) + prod_x;
      fcs_pkg::OP_R1:    acc_next = acc + prod_x;
      fcs_pkg::OP_R2:    acc_next = acc - prod_x;
      fcs_pkg::OP_UPD:   acc_next = prod_x + (54'sd1 <<< 15);
      default:           acc_next = acc;
    endcase
  end

  assign tgt_new = fcs_pkg::sat32(fcs_pkg::SUM_W'(pos[cmd.comp])
                                  + fcs_pkg::SUM_W'($signed(acc[53:14])));
  assign eye_d   = 34'(tgt) - 34'(eye[cmd.comp]);
  assign eye_r   = (eye_d + 34'sd2) >>> 2;
  assign eye_new = fcs_pkg::sat32(fcs_pkg::SUM_W'(eye[cmd.comp]) + fcs_pkg::SUM_W'(eye_r));
  assign aim_new = fcs_pkg::sat32(fcs_pkg::SUM_W'(aim[cmd.comp])
                                  + fcs_pkg::SUM_W'($signed(acc[53:16])));

  always_ff @(posedge clk) begin
    if (rst) begin
      offset[0] <= fcs_pkg::OFFSET_X_RST;
      offset[1] <= fcs_pkg::OFFSET_Y_RST;
      offset[2] <= fcs_pkg::OFFSET_Z_RST;
      look      <= fcs_pkg::LOOK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        fcs_pkg::REG_OFFSET_X: offset[0] <= cfg_data;
        fcs_pkg::REG_OFFSET_Y: offset[1] <= cfg_data;
        fcs_pkg::REG_OFFSET_Z: offset[2] <= cfg_data;
        fcs_pkg::REG_LOOK:     look      <= cfg_data[30:0];
        default:               look      <= look;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        eye[i] <= 32'sd0;
        aim[i] <= 32'sd0;
      end
    end else begin
      case (cmd.op)
        fcs_pkg::OP_UPD: begin
          if (!cmd.vec) begin
            eye[cmd.comp] <= smooth ? eye_new : tgt;
          end else if (!smooth) begin
            aim[cmd.comp] <= tgt;
          end
        end
        fcs_pkg::OP_FIN: begin
          if (cmd.vec && smooth) begin
            aim[cmd.comp] <= aim_new;
          end
        end
        default: begin
          eye[0] <= eye[0];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      smooth <= in_smooth;
      pos[0] <= in_data[31:0];
      pos[1] <= in_data[63:32];
      pos[2] <= in_data[95:64];
      q[0]   <= in_data[111:96];
      q[1]   <= in_data[127:112];
      q[2]   <= in_data[143:128];
      q[3]   <= in_data[159:144];
    end
    acc <= acc_next;
    if (cmd.op == fcs_pkg::OP_TSTORE) begin
      t[cmd.comp] <= acc[13 +: fcs_pkg::T_W];
    end
    if (cmd.op == fcs_pkg::OP_TGT) begin
      tgt <= tgt_new;
    end
    if (cmd.out_load) begin
      out_data <= {aim[2], aim[1], aim[0], eye[2], eye[1], eye[0]};
    end
  end

endmodule

FILE: verif/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the follow camera smoother: a scoreboard class
// keeps its own eye/aim state and register copy, predicts each output
// transfer from the accepted input, and compares it field by field.
// ---------------------------------------------------------------------------
module tb_top;

  typedef struct {
    logic signed [31:0] eye [3];
    logic signed [31:0] aim [3];
  } camera_t;

  class camera_scoreboard;
    longint offs [3];
    longint look;
    longint eye_st [3];
    longint aim_st [3];
    camera_t pending [$];
    int errors;

    function new();
      offs[0] = 0;
      offs[1] = 655360;
      offs[2] = -655360;
      look = 983040;
      for (int i = 0; i < 3; i++) begin
        eye_st[i] = 0;
        aim_st[i] = 0;
      end
      errors = 0;
    endfunction

    function longint round_shift(longint x, int s);
      longint y;
      y = x + (longint'(1) << (s - 1));
      return y >>> s;
    endfunction

    function longint clamp32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        fcs_pkg::REG_OFFSET_X: offs[0] = longint'(signed'(val));
        fcs_pkg::REG_OFFSET_Y: offs[1] = longint'(signed'(val));
        fcs_pkg::REG_OFFSET_Z: offs[2] = longint'(signed'(val));
        fcs_pkg::REG_LOOK:     look = longint'(val[30:0]);
        default:               look = look;
      endcase
    endfunction

    function void rotate_vec(longint q [4], longint v [3], output longint r [3]);
      longint t [3];
      longint c [3];
      t[0] = round_shift(q[2] * v[2] - q[3] * v[1], 13);
      t[1] = round_shift(q[3] * v[0] - q[1] * v[2], 13);
      t[2] = round_shift(q[1] * v[1] - q[2] * v[0], 13);
      c[0] = q[2] * t[2] - q[3] * t[1];
      c[1] = q[3] * t[0] - q[1] * t[2];
      c[2] = q[1] * t[1] - q[2] * t[0];
      for (int i = 0; i < 3; i++) r[i] = round_shift(v[i] * 16384 + q[0] * t[i] + c[i], 14);
    endfunction

    function void note_input(logic smooth, logic [159:0] d);
      longint pos [3];
      longint q [4];
      longint fwd [3];
      longint ro [3];
      longint rf [3];
      longint te;
      longint ta;
      camera_t res;
      for (int i = 0; i < 3; i++) pos[i] = longint'(signed'(d[32*i +: 32]));
      for (int i = 0; i < 4; i++) q[i] = longint'(signed'(d[96 + 16*i +: 16]));
      fwd[0] = 0;
      fwd[1] = 0;
      fwd[2] = look;
      rotate_vec(q, offs, ro);
      rotate_vec(q, fwd, rf);
      for (int i = 0; i < 3; i++) begin
        te = clamp32(pos[i] + ro[i]);
        ta = clamp32(pos[i] + rf[i]);
        if (smooth) begin
          eye_st[i] = clamp32(eye_st[i] + round_shift(te - eye_st[i], 2));
          aim_st[i] = clamp32(aim_st[i] + round_shift((ta - aim_st[i]) * 6554, 16));
        end else begin
          eye_st[i] = te;
          aim_st[i] = ta;
        end
        res.eye[i] = eye_st[i][31:0];
        res.aim[i] = aim_st[i][31:0];
      end
      pending.push_back(res);
    endfunction

    task check_result(logic [191:0] d);
      camera_t e;
      if (pending.size() == 0) begin
        report("output transfer with nothing expected", 0, d[31:0]);
        return;
      end
      e = pending.pop_front();
      for (int i = 0; i < 3; i++) begin
        if (d[32*i +: 32] !== e.eye[i]) report("eye mismatch", e.eye[i], d[32*i +: 32]);
        if (d[96 + 32*i +: 32] !== e.aim[i])
          report("aim mismatch", e.aim[i], d[96 + 32*i +: 32]);
      end
    endtask

    task report(string what, logic [31:0] exp_v, logic [31:0] got_v);
      errors++;
      if (errors <= 40) $display("ERROR %s: expected %h got %h", what, exp_v, got_v);
    endtask
  endclass

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [159:0] s_tdata;
  logic s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [191:0] m_tdata;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;

  camera_scoreboard sb;
  int send_idle;
  int recv_idle;

  follow_camera_smoother_top u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50000000;
    $display("** follow_camera_smoother_top: FAILED **");
    $finish;
  end

  // receiver: random stall, check every output transfer
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send_item(logic op, logic [159:0] d);
    while ($urandom_range(99) < send_idle) @(posedge clk);
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= d;
    do @(posedge clk); while (!s_tready);
    sb.note_input(op, d);
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom;
      default: return 32'(signed'($urandom_range(20000000)) - 10000000);
    endcase
  endfunction

  function automatic logic [159:0] rand_item();
    logic [159:0] d;
    logic [15:0] q [4];
    int a;
    for (int i = 0; i < 3; i++) d[32*i +: 32] = rand_pos();
    if ($urandom_range(9) < 8) begin
      // near-unit quaternion: one dominant part, small others
      a = $urandom_range(3);
      for (int i = 0; i < 4; i++) q[i] = 16'(signed'($urandom_range(8000)) - 4000);
      q[a] = $urandom_range(1) ? 16'd14000 : -16'sd14000;
    end else begin
      for (int i = 0; i < 4; i++) q[i] = $urandom;
    end
    for (int i = 0; i < 4; i++) d[96 + 16*i +: 16] = q[i];
    return d;
  endfunction

  function automatic logic [159:0] make_item(logic [31:0] p, logic [15:0] w, logic [15:0] x,
                                             logic [15:0] y, logic [15:0] z);
    return {z, y, x, w, p, p, p};
  endfunction

  initial begin
    sb = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    cfg_we = 1'b0;
    cfg_index = fcs_pkg::REG_OFFSET_X;
    cfg_data = '0;
    send_idle = 38;
    recv_idle = 81;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: identity, axis turns, extremes, non-unit quaternions
    send_item(1'b0, make_item(32'd0, 16'sd16384, 16'd0, 16'd0, 16'd0));
    send_item(1'b1, make_item(32'd65536, 16'd0, 16'sd16384, 16'd0, 16'd0));
    send_item(1'b1, make_item(32'h7FFFFFFF, 16'd0, 16'd0, 16'sd16384, 16'd0));
    send_item(1'b0, make_item(32'h80000000, 16'd0, 16'd0, 16'd0, 16'sd16384));
    send_item(1'b1, make_item(32'h7FFFFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
    send_item(1'b1, make_item(32'h80000000, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
    send_item(1'b0, make_item(32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_item(1'b1, make_item(32'd0, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF));
    drain();
    write_cfg(fcs_pkg::REG_OFFSET_X, 32'h7FFFFFFF);
    write_cfg(fcs_pkg::REG_OFFSET_Y, 32'h80000000);
    write_cfg(fcs_pkg::REG_OFFSET_Z, 32'h7FFFFFFF);
    write_cfg(fcs_pkg::REG_LOOK, 32'h7FFFFFFF);
    send_item(1'b0, make_item(32'h7FFFFFFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000));
    send_item(1'b1, make_item(32'h80000000, 16'sd11585, 16'sd11585, 16'd0, 16'd0));
    send_item(1'b1, make_item(32'd0, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
    drain();
    write_cfg(fcs_pkg::REG_OFFSET_X, 32'h80000000);
    write_cfg(fcs_pkg::REG_OFFSET_Z, 32'h80000000);
    write_cfg(fcs_pkg::REG_LOOK, 32'd0);
    send_item(1'b1, make_item(32'h80000000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
    send_item(1'b0, make_item(32'd12345, 16'sd16384, 16'd0, 16'd0, 16'd0));

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      send_idle = (ph < 2) ? 38 : (ph < 4) ? 81 : 0;
      recv_idle = (ph < 2) ? 81 : (ph < 4) ? 38 : 0;
      for (int r = 0; r < 4; r++)
        write_cfg(2'(r), (ph == 5) ? 32'd0 : ($urandom_range(1) ? $urandom :
                  32'(signed'($urandom_range(2000000)) - 1000000)));
      for (int n = 0; n < 175; n++) send_item($urandom_range(3) != 0, rand_item());
    end

    drain();
    if (sb.errors == 0) begin
      $display("** follow_camera_smoother_top: PASSED **");
    end else begin
      $display("** follow_camera_smoother_top: FAILED **");
    end
    $finish;
  end
endmodule
